// ===== design/tmcw_pkg.sv =====
// shared constants, types and codes of the text mode console writer
`timescale 1ns / 1ps
`default_nettype none
package tmcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    // derived widths
    localparam int MEM_AW  = $clog2(CELLS);
    localparam int COL_W   = $clog2(COLUMNS + 8);
    localparam int ROW_W   = $clog2(ROWS + 1);

    // field widths
    localparam int POS_W     = 11;
    localparam int CHAR_W    = 8;
    localparam int CELL_W    = 16;
    localparam int COLOR_W   = 4;
    localparam int ATTR_W    = 2 * COLOR_W;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // scroll walk bounds
    localparam int LAST_ROW_BASE = COLUMNS * (ROWS - 1);
    localparam int COPY_LAST     = LAST_ROW_BASE - 1;

    // cell constants
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [COL_W-1:0]  TAB_MASK   = ~COL_W'(7);
    localparam logic [COL_W-1:0]  TAB_STEP   = COL_W'(8);

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd1;

    // input beat
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CHAR_W-1:0] char_code;
        logic [POS_W-1:0]  read_addr;
    } req_t;

    // result beat
    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } result_t;

    // classified command
    typedef enum logic [2:0] {
        K_CHAR,
        K_NEWLINE,
        K_RETURN,
        K_TAB,
        K_BACKSPACE,
        K_CLEAR,
        K_READ,
        K_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CHAR_W-1:0] char_code;
        logic [POS_W-1:0]  read_addr;
    } cmd_t;

    // status between parts
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

    // back end sequencer
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_COPY,
        S_BLANK,
        S_RESP
    } back_state_t;

endpackage
`default_nettype wire

// ===== design/text_mode_console_writer_unit.sv =====
// top level of the text mode console writer: color registers and the three parts
// put (no scroll), read and unused requests: popped in S_IDLE, done in S_RESP; new ones queue meanwhile
// a scroll walks the buffer: COLUMNS*(ROWS-1) copies in S_COPY, then one row blank in S_BLANK
// clear fills every cell in S_BLANK; the command queue holds two items meanwhile
// after reset busy stays high while S_INIT sets every cell of the buffer to grey blanks
// results are one-cycle strobes on done; the receiver cannot stall them
`timescale 1ns / 1ps
`default_nettype none
module text_mode_console_writer_unit
    import tmcw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire req_t                 req,
    output logic                      done,
    output result_t                   result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data
);

    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;
    logic               push;
    logic               pop;
    cmd_t               push_cmd;
    cmd_t               pop_cmd;
    queue_status_t      qstat;
    back_status_t       bstat;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FOREGROUND: fg_next = cfg_data;
                CFG_BACKGROUND: bg_next = cfg_data;
                default:        fg_next = fg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= COLOR_W'(7);
            bg_reg <= '0;
        end
        else
        begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;
        end
    end

    // front end
    tmcw_front u_front (
        .start    (start),
        .req      (req),
        .qstat    (qstat),
        .bstat    (bstat),
        .busy     (busy),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // command queue
    tmcw_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (qstat)
    );

    // back end
    tmcw_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .attr    ({bg_reg, fg_reg}),
        .qstat   (qstat),
        .pop_cmd (pop_cmd),
        .pop     (pop),
        .bstat   (bstat),
        .done    (done),
        .result  (result)
    );

endmodule
`default_nettype wire

// ===== design/tmcw_front.sv =====
// front end: takes requests and classifies them into commands
`timescale 1ns / 1ps
`default_nettype none
module tmcw_front
    import tmcw_pkg::*;
(
    input  wire logic          start,
    input  wire req_t          req,
    input  wire queue_status_t qstat,
    input  wire back_status_t  bstat,
    output logic               busy,
    output logic               push,
    output cmd_t               push_cmd
);

    // hold off while the queue is full or the screen is being initialized
    assign busy = qstat.full | bstat.init_busy;
    assign push = start & ~busy;

    // decode request type and control characters
    always_comb
    begin
        push_cmd.char_code = req.char_code;
        push_cmd.read_addr = req.read_addr;
        case (req.req_type)
            REQ_PUT:
            begin
                case (req.char_code)
                    CH_NEWLINE:   push_cmd.kind = K_NEWLINE;
                    CH_RETURN:    push_cmd.kind = K_RETURN;
                    CH_TAB:       push_cmd.kind = K_TAB;
                    CH_BACKSPACE: push_cmd.kind = K_BACKSPACE;
                    default:      push_cmd.kind = K_CHAR;
                endcase
            end
            REQ_CLEAR: push_cmd.kind = K_CLEAR;
            REQ_READ:  push_cmd.kind = K_READ;
            default:   push_cmd.kind = K_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/tmcw_cmd_queue.sv =====
// short command queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module tmcw_cmd_queue
    import tmcw_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire cmd_t    push_cmd,
    input  wire logic    pop,
    output cmd_t         pop_cmd,
    output queue_status_t status
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // status and head
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_cmd      = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== design/tmcw_back.sv =====
// back end: cursor, screen buffer and the scroll and clear sequencer
`timescale 1ns / 1ps
`default_nettype none
module tmcw_back
    import tmcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [ATTR_W-1:0] attr,
    input  wire queue_status_t     qstat,
    input  wire cmd_t              pop_cmd,
    output logic                   pop,
    output back_status_t           bstat,
    output logic                   done,
    output result_t                result
);

    back_state_t       state_reg, state_next;
    logic [MEM_AW-1:0] cnt_reg, cnt_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              scrolled_reg, scrolled_next;
    logic              hit_reg, hit_next;
    logic              pend_reg, pend_next;
    logic [MEM_AW-1:0] pend_addr_reg, pend_addr_next;

    // screen memory ports
    logic [CELL_W-1:0] screen_mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [MEM_AW-1:0] mem_raddr;

    // put character evaluation
    logic [CELL_W-1:0] blank_cell;
    logic [MEM_AW-1:0] cur_base;
    logic [COL_W-1:0]  col_t;
    logic [ROW_W-1:0]  row_t;
    logic              row_inc;
    logic              scroll_t;
    logic              put_we;
    logic [MEM_AW-1:0] put_addr;
    logic [CELL_W-1:0] put_data;
    logic              is_put;

    assign blank_cell = {attr, BLANK_CHAR};
    assign cur_base   = MEM_AW'(row_reg * COLUMNS);
    assign is_put     = (pop_cmd.kind == K_CHAR) || (pop_cmd.kind == K_NEWLINE)
                     || (pop_cmd.kind == K_RETURN) || (pop_cmd.kind == K_TAB)
                     || (pop_cmd.kind == K_BACKSPACE);

    // cursor motion and cell write of a put command
    always_comb
    begin
        col_t    = col_reg;
        row_inc  = 1'b0;
        put_we   = 1'b0;
        put_addr = cur_base + MEM_AW'(col_reg);
        put_data = {attr, pop_cmd.char_code};
        case (pop_cmd.kind)
            K_NEWLINE:
            begin
                col_t   = '0;
                row_inc = 1'b1;
            end
            K_RETURN:
            begin
                col_t = '0;
            end
            K_TAB:
            begin
                col_t = (col_reg + TAB_STEP) & TAB_MASK;
            end
            K_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    col_t    = col_reg - 1'b1;
                    put_we   = 1'b1;
                    put_addr = cur_base + MEM_AW'(col_reg - 1'b1);
                    put_data = blank_cell;
                end
            end
            K_CHAR:
            begin
                col_t  = col_reg + 1'b1;
                put_we = 1'b1;
            end
            default:
            begin
                col_t = col_reg;
            end
        endcase
        // wrap at the row end
        if (col_t >= COL_W'(COLUMNS))
        begin
            col_t   = '0;
            row_inc = 1'b1;
        end
        row_t    = row_reg + ROW_W'(row_inc);
        scroll_t = (row_t >= ROW_W'(ROWS));
        if (scroll_t)
        begin
            row_t = ROW_W'(ROWS - 1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (cnt_reg == MEM_AW'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    if (pop_cmd.kind == K_CLEAR)
                    begin
                        state_next = S_BLANK;
                    end
                    else if (is_put && scroll_t)
                    begin
                        state_next = S_COPY;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_COPY:
            begin
                if (cnt_reg == MEM_AW'(COPY_LAST))
                begin
                    state_next = S_BLANK;
                end
            end
            S_BLANK:
            begin
                if (!pend_reg && cnt_reg == MEM_AW'(CELLS - 1))
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath next values
    always_comb
    begin
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg;
        mem_wdata      = blank_cell;
        mem_raddr      = cnt_reg;
        cnt_next       = cnt_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        scrolled_next  = scrolled_reg;
        hit_next       = hit_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = RESET_CELL;
                cnt_next  = cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop           = 1'b1;
                    scrolled_next = 1'b0;
                    hit_next      = 1'b0;
                    case (pop_cmd.kind)
                        K_CLEAR:
                        begin
                            row_next = '0;
                            col_next = '0;
                            cnt_next = '0;
                        end
                        K_READ:
                        begin
                            mem_raddr = MEM_AW'(pop_cmd.read_addr);
                            hit_next  = (pop_cmd.read_addr < POS_W'(CELLS));
                        end
                        K_NOP:
                        begin
                            hit_next = 1'b0;
                        end
                        default:
                        begin
                            mem_we        = put_we;
                            mem_waddr     = put_addr;
                            mem_wdata     = put_data;
                            row_next      = row_t;
                            col_next      = col_t;
                            scrolled_next = scroll_t;
                            cnt_next      = '0;
                        end
                    endcase
                end
            end
            S_COPY:
            begin
                // read one row below, write the cell read last cycle
                mem_raddr      = cnt_reg + MEM_AW'(COLUMNS);
                pend_next      = 1'b1;
                pend_addr_next = cnt_reg;
                mem_we         = pend_reg;
                mem_waddr      = pend_addr_reg;
                mem_wdata      = rdata_reg;
                cnt_next       = (cnt_reg == MEM_AW'(COPY_LAST))
                               ? MEM_AW'(LAST_ROW_BASE) : cnt_reg + 1'b1;
            end
            S_BLANK:
            begin
                mem_we = 1'b1;
                if (pend_reg)
                begin
                    // drain the last copy beat first
                    mem_waddr = pend_addr_reg;
                    mem_wdata = rdata_reg;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_RESP:
            begin
                hit_next = hit_reg;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // result beat
    assign done              = (state_reg == S_RESP);
    assign result.cursor_pos = POS_W'(row_reg * COLUMNS + col_reg);
    assign result.cell_data  = hit_reg ? rdata_reg : '0;
    assign result.scrolled   = scrolled_reg;
    assign bstat.init_busy   = (state_reg == S_INIT);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            cnt_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            scrolled_reg <= 1'b0;
            hit_reg      <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            scrolled_reg <= scrolled_next;
            hit_reg      <= hit_next;
            pend_reg     <= pend_next;
        end
    end

    // copy address
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
    end

    // screen memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= screen_mem[mem_raddr];
    end

endmodule
`default_nettype wire
